>>> sv/assert_macros.svh
// shared assertion macros, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scsd assertion failed");

// next-cycle implication
`define SCSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scsd assertion failed");

`endif

>>> sv/scsd_pkg.sv
`default_nettype none
package scsd_pkg;

  localparam int CHANNELS       = 6;
  localparam int PIN_W          = 6;
  localparam int LIMIT_CHANNELS = 2;
  localparam int TIMER_W        = 16;
  localparam int COUNT_W        = 8;
  localparam int INTERVAL_W     = 10;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // reset values of the configuration registers
  localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 10'd10;
  localparam logic [COUNT_W-1:0]    RST_SAMPLES_NEEDED  = 8'd3;
  localparam logic [TIMER_W-1:0]    RST_LIMIT_STABLE    = 16'd50;
  localparam logic [TIMER_W-1:0]    RST_PNEU_STABLE     = 16'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_NEEDED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_STABLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PNEU_STABLE     = 2'd3;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  typedef struct packed {
    logic             command;
    logic [PIN_W-1:0] pin_levels;
  } in_beat_t;

  typedef struct packed {
    logic [PIN_W-1:0] stable_pressed;
    logic [PIN_W-1:0] raw_pressed;
    logic [PIN_W-1:0] changed_mask;
    logic             limit_conflict;
    logic             grip_conflict;
    logic             vertical_conflict;
    logic             any_conflict;
  } out_beat_t;

  typedef struct packed {
    logic init;
    logic tick;
    logic sample;
  } lane_ctl_t;

endpackage
`default_nettype wire

>>> sv/scsd_lane.sv
`default_nettype none
module scsd_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scsd_pkg::lane_ctl_t           ctl,
  input  wire logic                          pressed,
  input  wire logic [scsd_pkg::TIMER_W-1:0]  stable_ms,
  input  wire logic [scsd_pkg::COUNT_W-1:0]  samples_needed,
  output logic                               raw_nxt,
  output logic                               filt_nxt,
  output logic                               changed
);

  logic                          raw_r;
  logic                          filt_r;
  logic [scsd_pkg::COUNT_W-1:0]  count_r;
  logic [scsd_pkg::COUNT_W-1:0]  count_nxt;
  logic [scsd_pkg::TIMER_W-1:0]  since_r;
  logic [scsd_pkg::TIMER_W-1:0]  since_nxt;
  logic [scsd_pkg::TIMER_W-1:0]  since_inc;
  logic [scsd_pkg::COUNT_W-1:0]  count_inc;

  assign since_inc = (since_r == scsd_pkg::TIMER_MAX) ? since_r : since_r + 1'b1;
  assign count_inc = (count_r == scsd_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;

  always_comb begin
    raw_nxt   = raw_r;
    filt_nxt  = filt_r;
    count_nxt = count_r;
    since_nxt = since_r;
    if (ctl.init) begin
      raw_nxt  = pressed;
      filt_nxt = pressed;
    end else if (ctl.tick) begin
      since_nxt = since_inc;
      if (ctl.sample) begin
        if (pressed != raw_r) begin
          // raw change restarts agreement
          raw_nxt   = pressed;
          count_nxt = {{(scsd_pkg::COUNT_W-1){1'b0}}, 1'b1};
          since_nxt = '0;
        end else begin
          count_nxt = count_inc;
          if ((count_inc >= samples_needed) && (since_inc >= stable_ms)) begin
            filt_nxt = pressed;
          end
        end
      end
    end
  end

  assign changed = ctl.tick & (filt_nxt ^ filt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r   <= 1'b0;
      filt_r  <= 1'b0;
      count_r <= '0;
      since_r <= '0;
    end else begin
      raw_r   <= raw_nxt;
      filt_r  <= filt_nxt;
      count_r <= count_nxt;
      since_r <= since_nxt;
    end
  end

`include "assert_macros.svh"

  `SCSD_ASSERT_NXT(a_change_restarts, clk, rst_n, ctl.tick && !ctl.init && ctl.sample && (pressed != raw_r), (count_r == 1) && (since_r == 0))
  `SCSD_ASSERT_NXT(a_init_aligns, clk, rst_n, ctl.init, raw_r == filt_r)

endmodule
`default_nettype wire

>>> sv/scsd_merge.sv
`default_nettype none
module scsd_merge (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire logic [scsd_pkg::PIN_W-1:0]   stable,
  input  wire logic [scsd_pkg::PIN_W-1:0]   raw,
  input  wire logic [scsd_pkg::PIN_W-1:0]   changed,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output scsd_pkg::out_beat_t               out_beat
);

  logic                 out_valid_r;
  scsd_pkg::out_beat_t  beat_r;
  scsd_pkg::out_beat_t  beat_nxt;

  always_comb begin
    beat_nxt.stable_pressed    = stable;
    beat_nxt.raw_pressed       = raw;
    beat_nxt.changed_mask      = changed;
    beat_nxt.limit_conflict    = stable[0] & stable[1];
    beat_nxt.grip_conflict     = stable[2] & stable[3];
    beat_nxt.vertical_conflict = stable[4] & stable[5];
    beat_nxt.any_conflict      = beat_nxt.limit_conflict | beat_nxt.grip_conflict
                               | beat_nxt.vertical_conflict;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = beat_r;

`include "assert_macros.svh"

  `SCSD_ASSERT_NXT(a_load_shows, clk, rst_n, load, out_valid_r)

endmodule
`default_nettype wire

>>> sv/six_channel_switch_debouncer_unit.sv
// channel  | signals                          | role
// input    | in_valid, in_ready, in_beat      | one tick or init command per beat
// result   | out_valid, out_ready, out_beat   | one filtered status beat per input beat
// config   | cfg_wr_en, cfg_index, cfg_wdata  | register writes, no wait, no read-back
//
// one input beat per cycle unless stalled; each result shows in the cycle after its input beat
// all lanes update in parallel in the cycle of acceptance, the output register holds the result
// in_ready stays high while the output register is empty or being drained this cycle
// synchronous active-low reset clears timers, counts, states and config to defaults
// a stalled result holds the output register and blocks new input until it is taken
`default_nettype none
module six_channel_switch_debouncer_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire scsd_pkg::in_beat_t                in_beat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output scsd_pkg::out_beat_t                    out_beat,
  input  wire logic                              cfg_wr_en,
  input  wire logic [scsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [scsd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [scsd_pkg::INTERVAL_W-1:0] interval_r;
  logic [scsd_pkg::COUNT_W-1:0]    needed_r;
  logic [scsd_pkg::TIMER_W-1:0]    limit_ms_r;
  logic [scsd_pkg::TIMER_W-1:0]    pneu_ms_r;

  // shared sample interval timer
  logic [scsd_pkg::TIMER_W-1:0]    timer_r;
  logic [scsd_pkg::TIMER_W-1:0]    timer_inc;
  logic                            sample;

  logic                            accept;
  scsd_pkg::lane_ctl_t             ctl;
  logic [scsd_pkg::PIN_W-1:0]      pressed_all;

  // per-lane results, then trimmed to the six reported channels
  logic [scsd_pkg::CHANNELS-1:0]   lane_raw;
  logic [scsd_pkg::CHANNELS-1:0]   lane_filt;
  logic [scsd_pkg::CHANNELS-1:0]   lane_chg;
  logic [scsd_pkg::PIN_W-1:0]      stable_v;
  logic [scsd_pkg::PIN_W-1:0]      raw_v;
  logic [scsd_pkg::PIN_W-1:0]      chg_v;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // low level means pressed
  assign pressed_all = ~in_beat.pin_levels;

  // timer advances first, then compares against the interval
  assign timer_inc = (timer_r == scsd_pkg::TIMER_MAX) ? timer_r : timer_r + 1'b1;
  assign sample    = timer_inc >= {{(scsd_pkg::TIMER_W-scsd_pkg::INTERVAL_W){1'b0}}, interval_r};

  assign ctl.init   = accept && (in_beat.command == scsd_pkg::CMD_INIT);
  assign ctl.tick   = accept && (in_beat.command == scsd_pkg::CMD_TICK);
  assign ctl.sample = sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else if (ctl.tick) begin
      timer_r <= sample ? '0 : timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= scsd_pkg::RST_SAMPLE_INTERVAL;
      needed_r   <= scsd_pkg::RST_SAMPLES_NEEDED;
      limit_ms_r <= scsd_pkg::RST_LIMIT_STABLE;
      pneu_ms_r  <= scsd_pkg::RST_PNEU_STABLE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        scsd_pkg::CFG_SAMPLE_INTERVAL: interval_r <= cfg_wdata[scsd_pkg::INTERVAL_W-1:0];
        scsd_pkg::CFG_SAMPLES_NEEDED:  needed_r   <= cfg_wdata[scsd_pkg::COUNT_W-1:0];
        scsd_pkg::CFG_LIMIT_STABLE:    limit_ms_r <= cfg_wdata[scsd_pkg::TIMER_W-1:0];
        scsd_pkg::CFG_PNEU_STABLE:     pneu_ms_r  <= cfg_wdata[scsd_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // one debounce lane per channel
  for (genvar c = 0; c < scsd_pkg::CHANNELS; c++) begin : g_lane
    logic                         lane_pressed;
    logic [scsd_pkg::TIMER_W-1:0] lane_need;

    if (c < scsd_pkg::PIN_W) begin : g_pin
      assign lane_pressed = pressed_all[c];
    end else begin : g_nopin
      // channels beyond the pin field always read released
      assign lane_pressed = 1'b0;
    end

    // limit switches use their own stable time, the shorter one at reset
    if (c < scsd_pkg::LIMIT_CHANNELS) begin : g_limit
      assign lane_need = limit_ms_r;
    end else begin : g_pneu
      assign lane_need = pneu_ms_r;
    end

    scsd_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .pressed        (lane_pressed),
      .stable_ms      (lane_need),
      .samples_needed (needed_r),
      .raw_nxt        (lane_raw[c]),
      .filt_nxt       (lane_filt[c]),
      .changed        (lane_chg[c])
    );
  end

  // missing channels report released, extra channels are dropped
  for (genvar i = 0; i < scsd_pkg::PIN_W; i++) begin : g_trim
    if (i < scsd_pkg::CHANNELS) begin : g_have
      assign stable_v[i] = lane_filt[i];
      assign raw_v[i]    = lane_raw[i];
      assign chg_v[i]    = lane_chg[i];
    end else begin : g_miss
      assign stable_v[i] = 1'b0;
      assign raw_v[i]    = 1'b0;
      assign chg_v[i]    = 1'b0;
    end
  end

  scsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .stable    (stable_v),
    .raw       (raw_v),
    .changed   (chg_v),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

`include "assert_macros.svh"

  `SCSD_ASSERT_NXT(a_sample_clears_timer, clk, rst_n, ctl.tick && sample, timer_r == 0)

endmodule
`default_nettype wire
